### hdl/pett_pkg.sv
package pett_pkg;

    localparam int PID_W = 23;
    localparam int CODE_W = 16;
    localparam int STAMP_W = 64;
    localparam int CNT_W = 64;

    typedef enum logic [2:0] {
        OP_FORK    = 3'd0,
        OP_EXEC    = 3'd1,
        OP_EXIT    = 3'd2,
        OP_PTRACE  = 3'd3,
        OP_OTHER   = 3'd4,
        OP_UNKNOWN = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        VERB_START = 2'd0,
        VERB_STOP  = 2'd1,
        VERB_RAW   = 2'd2
    } verb_t;

    localparam logic REG_MONITOR_PID = 1'b0;
    localparam logic REG_REPORT_MONITOR = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PRD,
        ST_PEV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [PID_W-1:0]   parent;
        logic [STAMP_W-1:0] stamp;
        logic               running;
    } entry_t;

    typedef struct packed {
        logic start;
        logic mod_step;
        logic probe_issue;
        logic probe_eval;
        logic commit;
        logic clear_wr;
    } cmd_t;

    typedef struct packed {
        logic ign;
        logic skip_scan;
        logic mod_last;
        logic probe_last;
        logic clear_last;
        logic result_due;
        logic out_free;
    } status_t;

endpackage

### hdl/pett_ctrl.sv
module pett_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pett_pkg::status_t  st,
    output pett_pkg::cmd_t     cmd
);

    pett_pkg::state_t state_reg;
    pett_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pett_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            pett_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last)
                begin
                    state_next = pett_pkg::ST_IDLE;
                end
            end
            pett_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    state_next = pett_pkg::ST_MOD;
                end
            end
            pett_pkg::ST_MOD:
            begin
                if (st.ign)
                begin
                    state_next = pett_pkg::ST_IDLE;
                end
                else if (st.skip_scan)
                begin
                    state_next = pett_pkg::ST_COMMIT;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                    if (st.mod_last)
                    begin
                        state_next = pett_pkg::ST_PRD;
                    end
                end
            end
            pett_pkg::ST_PRD:
            begin
                cmd.probe_issue = 1'b1;
                state_next = pett_pkg::ST_PEV;
            end
            pett_pkg::ST_PEV:
            begin
                cmd.probe_eval = 1'b1;
                state_next = st.probe_last ? pett_pkg::ST_COMMIT : pett_pkg::ST_PRD;
            end
            pett_pkg::ST_COMMIT:
            begin
                // hold until the output register can take the item
                if (!st.result_due || st.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = pett_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pett_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/pett_dp.sv
module pett_dp
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int PROBE_LENGTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pett_pkg::cmd_t                cmd,
    output pett_pkg::status_t             st,
    input  logic [pett_pkg::PID_W-1:0]    monitor_pid,
    input  logic                          report_monitor,
    input  logic [2:0]                    op,
    input  logic [pett_pkg::PID_W-1:0]    subject_pid,
    input  logic [pett_pkg::PID_W-1:0]    other_pid,
    input  logic [pett_pkg::CODE_W-1:0]   event_code,
    input  logic [pett_pkg::STAMP_W-1:0]  stamp_ns,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    verb,
    output logic [pett_pkg::PID_W-1:0]    pid_out,
    output logic [pett_pkg::PID_W-1:0]    initiator_pid,
    output logic [pett_pkg::PID_W-1:0]    parent_pid,
    output logic                          parent_missing,
    output logic [pett_pkg::CODE_W-1:0]   raw_id,
    output logic [pett_pkg::CNT_W-1:0]    sequence_res,
    output logic [pett_pkg::CNT_W-1:0]    evictions
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int PRB_W = $clog2(PROBE_LENGTH + 1);
    localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(TABLE_ENTRIES);
    localparam int PID_W = pett_pkg::PID_W;
    // quotient by reciprocal: exact for every pid below 2^PID_W
    localparam int RCP_SH = PID_W + IDX_W;
    localparam longint RCP_VAL = ((longint'(1) << RCP_SH) + longint'(TABLE_ENTRIES)
                                  - longint'(1)) / longint'(TABLE_ENTRIES);
    localparam int RCP_W = PID_W + 2;
    localparam int PROD_W = PID_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);
    localparam logic [PID_W-1:0] N_PID = PID_W'(TABLE_ENTRIES);

    pett_pkg::entry_t mem [TABLE_ENTRIES];
    pett_pkg::entry_t mem_q;

    logic [2:0]                   op_reg;
    logic [PID_W-1:0]             pid_reg;
    logic [PID_W-1:0]             other_reg;
    logic [pett_pkg::CODE_W-1:0]  code_reg;
    logic [pett_pkg::STAMP_W-1:0] stamp_reg;

    logic                         mod_ph_reg;
    logic [PID_W-1:0]             quot_reg;
    logic [IDX_W-1:0]             cur_reg;
    logic [PRB_W-1:0]             prb_cnt_reg;
    logic [IDX_W-1:0]             clr_cnt_reg;

    logic                         hit_reg;
    logic [IDX_W-1:0]             hit_idx_reg;
    logic [PID_W-1:0]             hit_parent_reg;
    logic                         hit_run_reg;
    logic                         free_v_reg;
    logic [IDX_W-1:0]             free_idx_reg;
    logic                         old_v_reg;
    logic [IDX_W-1:0]             old_idx_reg;
    logic [pett_pkg::STAMP_W-1:0] old_stamp_reg;

    logic [pett_pkg::CNT_W-1:0]   rec_cnt_reg;
    logic [pett_pkg::CNT_W-1:0]   evict_cnt_reg;

    logic                         out_valid_reg;
    logic [1:0]                   verb_reg;
    logic [PID_W-1:0]             pid_out_reg;
    logic [PID_W-1:0]             actor_reg;
    logic [PID_W-1:0]             parent_reg;
    logic                         missing_reg;
    logic [pett_pkg::CODE_W-1:0]  raw_reg;
    logic [pett_pkg::CNT_W-1:0]   seq_reg;
    logic [pett_pkg::CNT_W-1:0]   evo_reg;

    logic [PROD_W-1:0]            prod;
    logic [PID_W-1:0]             home;
    logic [IDX_W:0]               cur_inc;
    logic [IDX_W-1:0]             cur_next;

    logic                         filt;
    logic [IDX_W-1:0]             claim_idx;
    logic                         claim_evict;
    logic                         we;
    logic [IDX_W-1:0]             waddr;
    pett_pkg::entry_t             wdata;
    logic                         result_due;
    logic                         evict_inc;
    logic [1:0]                   res_verb;
    logic [PID_W-1:0]             res_actor;
    logic [PID_W-1:0]             res_parent;
    logic                         res_missing;
    logic [pett_pkg::CODE_W-1:0]  res_raw;
    logic [pett_pkg::CNT_W-1:0]   evict_after;

    // home slot: the quotient is registered first, then the remainder gives the start slot
    always_comb
    begin
        prod = {RCP_W'(0), pid_reg} * {PID_W'(0), RCP};
        home = pid_reg - quot_reg * N_PID;
        cur_inc = {1'b0, cur_reg} + (IDX_W+1)'(1);
        cur_next = (cur_inc == N_EXT) ? '0 : cur_inc[IDX_W-1:0];
    end

    always_comb
    begin
        filt = !report_monitor && (pid_reg == monitor_pid);
        claim_evict = !hit_reg && !free_v_reg;
        claim_idx = hit_reg ? hit_idx_reg : (free_v_reg ? free_idx_reg : old_idx_reg);
        we = 1'b0;
        waddr = claim_idx;
        wdata = '0;
        result_due = 1'b0;
        evict_inc = 1'b0;
        res_verb = pett_pkg::VERB_RAW;
        res_actor = '0;
        res_parent = '0;
        res_missing = 1'b0;
        res_raw = '0;
        case (op_reg)
            pett_pkg::OP_FORK:
            begin
                we = 1'b1;
                evict_inc = claim_evict;
                wdata.pid = pid_reg;
                wdata.parent = other_reg;
                wdata.stamp = stamp_reg;
                wdata.running = hit_reg && hit_run_reg;
            end
            pett_pkg::OP_EXEC:
            begin
                if (!filt)
                begin
                    we = 1'b1;
                    evict_inc = claim_evict;
                    res_parent = hit_reg ? hit_parent_reg : '0;
                    wdata.pid = pid_reg;
                    wdata.parent = res_parent;
                    wdata.stamp = stamp_reg;
                    wdata.running = 1'b1;
                    result_due = 1'b1;
                    res_verb = pett_pkg::VERB_START;
                    res_actor = res_parent;
                    res_missing = (res_parent == '0);
                end
            end
            pett_pkg::OP_EXIT:
            begin
                waddr = hit_idx_reg;
                if (hit_reg && !hit_run_reg)
                begin
                    we = 1'b1;
                end
                else if (hit_reg && !filt)
                begin
                    we = 1'b1;
                    result_due = 1'b1;
                    res_verb = pett_pkg::VERB_STOP;
                    res_actor = pid_reg;
                    res_parent = hit_parent_reg;
                    res_missing = (hit_parent_reg == '0);
                end
            end
            pett_pkg::OP_PTRACE,
            pett_pkg::OP_OTHER:
            begin
                if (!filt)
                begin
                    result_due = 1'b1;
                    res_verb = pett_pkg::VERB_RAW;
                    res_actor = (op_reg == pett_pkg::OP_PTRACE) ? other_reg : pid_reg;
                    res_raw = code_reg;
                end
            end
            default:
            begin
                result_due = 1'b0;
            end
        endcase
        evict_after = evict_cnt_reg + pett_pkg::CNT_W'(evict_inc);
    end

    always_comb
    begin
        st.ign = (pid_reg == '0) || (op_reg > 3'(pett_pkg::OP_OTHER))
                 || (op_reg == pett_pkg::OP_UNKNOWN);
        st.skip_scan = (op_reg == pett_pkg::OP_PTRACE) || (op_reg == pett_pkg::OP_OTHER)
                       || ((op_reg == pett_pkg::OP_EXEC) && filt);
        st.mod_last = mod_ph_reg;
        st.probe_last = (prb_cnt_reg == PRB_W'(PROBE_LENGTH - 1));
        st.clear_last = (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1));
        st.result_due = result_due;
        st.out_free = !out_valid_reg || !out_stall;
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.commit && we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_issue)
        begin
            mem_q <= mem[cur_reg];
        end
    end

    // item capture, home slot and probe scan
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= op;
            pid_reg <= subject_pid;
            other_reg <= other_pid;
            code_reg <= event_code;
            stamp_reg <= stamp_ns;
            mod_ph_reg <= 1'b0;
            prb_cnt_reg <= '0;
            hit_reg <= 1'b0;
            free_v_reg <= 1'b0;
            old_v_reg <= 1'b0;
        end
        if (cmd.mod_step)
        begin
            if (!mod_ph_reg)
            begin
                quot_reg <= PID_W'(prod >> RCP_SH);
                mod_ph_reg <= 1'b1;
            end
            else
            begin
                cur_reg <= home[IDX_W-1:0];
            end
        end
        if (cmd.probe_eval)
        begin
            if (!hit_reg && mem_q.pid == pid_reg)
            begin
                hit_reg <= 1'b1;
                hit_idx_reg <= cur_reg;
                hit_parent_reg <= mem_q.parent;
                hit_run_reg <= mem_q.running;
            end
            if (!free_v_reg && mem_q.pid == '0)
            begin
                free_v_reg <= 1'b1;
                free_idx_reg <= cur_reg;
            end
            // strict compare keeps the first probed among equal stamps
            if (!old_v_reg || mem_q.stamp < old_stamp_reg)
            begin
                old_v_reg <= 1'b1;
                old_idx_reg <= cur_reg;
                old_stamp_reg <= mem_q.stamp;
            end
            cur_reg <= cur_next;
            prb_cnt_reg <= prb_cnt_reg + PRB_W'(1);
        end
        if (cmd.commit && result_due)
        begin
            verb_reg <= res_verb;
            pid_out_reg <= pid_reg;
            actor_reg <= res_actor;
            parent_reg <= res_parent;
            missing_reg <= res_missing;
            raw_reg <= res_raw;
            seq_reg <= rec_cnt_reg;
            evo_reg <= evict_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            rec_cnt_reg <= '0;
            evict_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.commit)
            begin
                evict_cnt_reg <= evict_after;
                if (result_due)
                begin
                    rec_cnt_reg <= rec_cnt_reg + pett_pkg::CNT_W'(1);
                end
            end
            if (cmd.commit && result_due)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign verb = verb_reg;
    assign pid_out = pid_out_reg;
    assign initiator_pid = actor_reg;
    assign parent_pid = parent_reg;
    assign parent_missing = missing_reg;
    assign raw_id = raw_reg;
    assign sequence_res = seq_reg;
    assign evictions = evo_reg;

endmodule

### hdl/process_event_tracking_table_top.sv
// Process event table keyed by pid, with open addressing and a bounded linear
// probe. After reset the block sweeps the table clear, one entry a cycle, and
// accepts no item meanwhile. A fork, exec or exit item is captured, finds its
// home slot by a reciprocal multiply for the quotient and then a multiply-
// subtract for the remainder, scans PROBE_LENGTH slots, each probe a read of
// the table memory followed by an evaluate step, and then commits. Ptrace and
// other events, and an exec of the monitored pid, skip the home slot and the
// scan and go straight to commit; ignored events are dropped after capture.
// A finished result waits in the output register while the next item is
// taken; an item with a result holds in its commit state for as long as the
// previous result is still stalled there.
module process_event_tracking_table_top
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int PROBE_LENGTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    op,
    input  logic [pett_pkg::PID_W-1:0]    subject_pid,
    input  logic [pett_pkg::PID_W-1:0]    other_pid,
    input  logic [pett_pkg::CODE_W-1:0]   event_code,
    input  logic [pett_pkg::STAMP_W-1:0]  stamp_ns,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    verb,
    output logic [pett_pkg::PID_W-1:0]    pid_out,
    output logic [pett_pkg::PID_W-1:0]    initiator_pid,
    output logic [pett_pkg::PID_W-1:0]    parent_pid,
    output logic                          parent_missing,
    output logic [pett_pkg::CODE_W-1:0]   raw_id,
    output logic [pett_pkg::CNT_W-1:0]    sequence_res,
    output logic [pett_pkg::CNT_W-1:0]    evictions,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [pett_pkg::PID_W-1:0]    cfg_data
);

    logic [pett_pkg::PID_W-1:0] monitor_pid_reg;
    logic                       report_monitor_reg;
    pett_pkg::cmd_t             cmd;
    pett_pkg::status_t          st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitor_pid_reg <= '0;
            report_monitor_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pett_pkg::REG_MONITOR_PID:    monitor_pid_reg <= cfg_data;
                pett_pkg::REG_REPORT_MONITOR: report_monitor_reg <= cfg_data[0];
                default:                      monitor_pid_reg <= monitor_pid_reg;
            endcase
        end
    end

    pett_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    pett_dp
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PROBE_LENGTH  (PROBE_LENGTH)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .monitor_pid    (monitor_pid_reg),
        .report_monitor (report_monitor_reg),
        .op             (op),
        .subject_pid    (subject_pid),
        .other_pid      (other_pid),
        .event_code     (event_code),
        .stamp_ns       (stamp_ns),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verb           (verb),
        .pid_out        (pid_out),
        .initiator_pid  (initiator_pid),
        .parent_pid     (parent_pid),
        .parent_missing (parent_missing),
        .raw_id         (raw_id),
        .sequence_res   (sequence_res),
        .evictions      (evictions)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");

    a_raw_no_parent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verb == pett_pkg::VERB_RAW) |-> (parent_pid == '0 && !parent_missing))
        else $error("raw item carries parent");

    a_start_missing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verb == pett_pkg::VERB_START) |-> (parent_missing == (parent_pid == '0)))
        else $error("start item parent flag mismatch");

    a_start_actor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verb == pett_pkg::VERB_START) |-> (initiator_pid == parent_pid))
        else $error("start item actor differs from parent");

endmodule

### verif/process_event_tracking_table_top_tb.sv
`timescale 1ns / 100ps

module process_event_tracking_table_top_tb;

    localparam int TBL_N = 4096;
    localparam int PROBE_N = 8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 230;

    typedef struct packed {
        logic [1:0]                   verb;
        logic [pett_pkg::PID_W-1:0]   pid;
        logic [pett_pkg::PID_W-1:0]   actor;
        logic [pett_pkg::PID_W-1:0]   parent;
        logic                         missing;
        logic [pett_pkg::CODE_W-1:0]  raw;
        logic [pett_pkg::CNT_W-1:0]   seq;
        logic [pett_pkg::CNT_W-1:0]   evict;
    } record_t;

    class event_table_sb;
        logic [pett_pkg::PID_W-1:0]   slot_pid_q[TBL_N];
        logic [pett_pkg::PID_W-1:0]   slot_par_q[TBL_N];
        logic [pett_pkg::STAMP_W-1:0] slot_stamp_q[TBL_N];
        logic                         slot_run_q[TBL_N];
        logic [pett_pkg::CNT_W-1:0]   rec_cnt;
        logic [pett_pkg::CNT_W-1:0]   evict_cnt;
        logic [pett_pkg::PID_W-1:0]   monitor_pid;
        logic                         report_monitor;
        record_t                      pending[$];
        int                           errors;

        function new();
            for (int i = 0; i < TBL_N; i++)
                wipe(i);
            rec_cnt = '0;
            evict_cnt = '0;
            monitor_pid = '0;
            report_monitor = 1'b0;
            errors = 0;
        endfunction

        function void wipe(int s);
            slot_pid_q[s] = '0;
            slot_par_q[s] = '0;
            slot_stamp_q[s] = '0;
            slot_run_q[s] = 1'b0;
        endfunction

        function int find(logic [pett_pkg::PID_W-1:0] pid);
            logic [11:0] s;
            for (int i = 0; i < PROBE_N; i++)
            begin
                s = pid[11:0] + i[11:0];
                if (slot_pid_q[s] == pid)
                    return int'(s);
            end
            return -1;
        endfunction

        function int claim(logic [pett_pkg::PID_W-1:0] pid);
            logic [11:0] s;
            int free_s;
            int old_s;
            free_s = -1;
            old_s = -1;
            for (int i = 0; i < PROBE_N; i++)
            begin
                s = pid[11:0] + i[11:0];
                if (slot_pid_q[s] == pid)
                    return int'(s);
                if (slot_pid_q[s] == '0 && free_s < 0)
                    free_s = int'(s);
                if (old_s < 0 || slot_stamp_q[s] < slot_stamp_q[old_s])
                    old_s = int'(s);
            end
            if (free_s < 0)
            begin
                free_s = old_s;
                evict_cnt++;
            end
            wipe(free_s);
            slot_pid_q[free_s] = pid;
            return free_s;
        endfunction

        function void note_item(logic [2:0] op, logic [pett_pkg::PID_W-1:0] pid,
                                logic [pett_pkg::PID_W-1:0] other,
                                logic [pett_pkg::CODE_W-1:0] code,
                                logic [pett_pkg::STAMP_W-1:0] stamp);
            record_t r;
            int s;
            if (pid == '0 || op > pett_pkg::OP_OTHER)
                return;
            if (op == pett_pkg::OP_FORK)
            begin
                s = claim(pid);
                slot_par_q[s] = other;
                slot_stamp_q[s] = stamp;
                return;
            end
            if (op == pett_pkg::OP_EXIT)
            begin
                s = find(pid);
                if (s < 0)
                    return;
                if (!slot_run_q[s])
                begin
                    wipe(s);
                    return;
                end
            end
            if (!report_monitor && pid == monitor_pid)
                return;
            r = '0;
            r.pid = pid;
            if (op == pett_pkg::OP_PTRACE || op == pett_pkg::OP_OTHER)
            begin
                r.verb = pett_pkg::VERB_RAW;
                r.raw = code;
                r.actor = (op == pett_pkg::OP_PTRACE) ? other : pid;
            end
            else if (op == pett_pkg::OP_EXIT)
            begin
                r.verb = pett_pkg::VERB_STOP;
                r.actor = pid;
                s = find(pid);
                if (s >= 0)
                begin
                    if (slot_par_q[s] != '0)
                        r.parent = slot_par_q[s];
                    else
                        r.missing = 1'b1;
                    wipe(s);
                end
            end
            else
            begin
                r.verb = pett_pkg::VERB_START;
                s = claim(pid);
                slot_run_q[s] = 1'b1;
                slot_stamp_q[s] = stamp;
                if (slot_par_q[s] != '0)
                begin
                    r.parent = slot_par_q[s];
                    r.actor = r.parent;
                end
                else
                    r.missing = 1'b1;
            end
            r.seq = rec_cnt;
            r.evict = evict_cnt;
            rec_cnt++;
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(record_t got);
            record_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("verb", 64'(e.verb), 64'(got.verb));
            cmp("pid_out", 64'(e.pid), 64'(got.pid));
            cmp("initiator_pid", 64'(e.actor), 64'(got.actor));
            cmp("parent_pid", 64'(e.parent), 64'(got.parent));
            cmp("parent_missing", 64'(e.missing), 64'(got.missing));
            cmp("raw_id", 64'(e.raw), 64'(got.raw));
            cmp("sequence_res", e.seq, got.seq);
            cmp("evictions", e.evict, got.evict);
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [2:0]                     op;
    logic [pett_pkg::PID_W-1:0]     subject_pid;
    logic [pett_pkg::PID_W-1:0]     other_pid;
    logic [pett_pkg::CODE_W-1:0]    event_code;
    logic [pett_pkg::STAMP_W-1:0]   stamp_ns;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     verb;
    logic [pett_pkg::PID_W-1:0]     pid_out;
    logic [pett_pkg::PID_W-1:0]     initiator_pid;
    logic [pett_pkg::PID_W-1:0]     parent_pid;
    logic                           parent_missing;
    logic [pett_pkg::CODE_W-1:0]    raw_id;
    logic [pett_pkg::CNT_W-1:0]     sequence_res;
    logic [pett_pkg::CNT_W-1:0]     evictions;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [pett_pkg::PID_W-1:0]     cfg_data;

    event_table_sb sb;
    int  cycles = 0;
    bit  tx_idle;
    bit  rx_idle;
    int  idle_pct;
    bit  hold_go;
    int  hold_left = 3000;

    process_event_tracking_table_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .subject_pid(subject_pid), .other_pid(other_pid),
        .event_code(event_code), .stamp_ns(stamp_ns),
        .out_valid(out_valid), .out_stall(out_stall),
        .verb(verb), .pid_out(pid_out), .initiator_pid(initiator_pid),
        .parent_pid(parent_pid), .parent_missing(parent_missing),
        .raw_id(raw_id), .sequence_res(sequence_res), .evictions(evictions),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("process_event_tracking_table_top_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stall, or one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= rx_idle && ($urandom_range(99) < idle_pct);
    end

    // outputs and stall are stable at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({verb, pid_out, initiator_pid, parent_pid, parent_missing,
                             raw_id, sequence_res, evictions});
    end

    task automatic send_item(logic [2:0] o, logic [pett_pkg::PID_W-1:0] p,
                             logic [pett_pkg::PID_W-1:0] q,
                             logic [pett_pkg::CODE_W-1:0] c,
                             logic [pett_pkg::STAMP_W-1:0] t);
        bit acc;
        int gap;
        gap = 0;
        while (tx_idle && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        subject_pid <= p;
        other_pid <= q;
        event_code <= c;
        stamp_ns <= t;
        acc = 1'b0;
        while (!acc)
        begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
        end
        sb.note_item(o, p, q, c, t);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // a last item may still be in the probe without a record
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [pett_pkg::PID_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pett_pkg::REG_MONITOR_PID)
            sb.monitor_pid = val;
        else
            sb.report_monitor = val[0];
    endtask

    function automatic logic [pett_pkg::PID_W-1:0] pool_pid();
        logic [11:0] home;
        case ($urandom_range(3))
            0: home = 12'd1;
            1: home = 12'd2;
            2: home = 12'd4093;
            default: home = 12'd4095;
        endcase
        return pett_pkg::PID_W'(home)
               + pett_pkg::PID_W'($urandom_range(11)) * pett_pkg::PID_W'(TBL_N);
    endfunction

    task automatic send_random();
        logic [2:0] o;
        logic [pett_pkg::PID_W-1:0] p;
        logic [pett_pkg::PID_W-1:0] q;
        logic [pett_pkg::STAMP_W-1:0] t;
        int r;
        r = $urandom_range(99);
        if (r < 30) o = pett_pkg::OP_FORK;
        else if (r < 55) o = pett_pkg::OP_EXEC;
        else if (r < 80) o = pett_pkg::OP_EXIT;
        else if (r < 87) o = pett_pkg::OP_PTRACE;
        else if (r < 94) o = pett_pkg::OP_OTHER;
        else o = 3'($urandom_range(7, 5));
        r = $urandom_range(99);
        if (r < 75) p = pool_pid();
        else if (r < 78) p = '0;
        else p = pett_pkg::PID_W'($urandom);
        q = ($urandom_range(3) == 0) ? '0 : pett_pkg::PID_W'($urandom);
        t = ($urandom_range(1) == 0) ? pett_pkg::STAMP_W'($urandom_range(7))
                                     : {$urandom, $urandom};
        send_item(o, p, q, pett_pkg::CODE_W'($urandom), t);
    endtask

    initial
    begin
        logic [pett_pkg::PID_W-1:0] monitor_set[5];
        logic                       report_set[5];
        sb = new();
        tx_idle = 0;
        rx_idle = 0;
        idle_pct = 69;
        hold_go = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = '0;
        subject_pid = '0;
        other_pid = '0;
        event_code = '0;
        stamp_ns = '0;
        cfg_we = 1'b0;
        cfg_index = pett_pkg::REG_MONITOR_PID;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(pett_pkg::REG_MONITOR_PID, '0);
        write_reg(pett_pkg::REG_REPORT_MONITOR, '0);

        send_item(pett_pkg::OP_FORK, 23'd100, 23'd7, 16'd0, 64'd5);
        send_item(pett_pkg::OP_EXEC, 23'd100, 23'd0, 16'd1, 64'd6);
        send_item(pett_pkg::OP_FORK, 23'd100, 23'd9, 16'd0, 64'd8);
        send_item(pett_pkg::OP_EXIT, 23'd100, 23'd0, 16'd0, 64'd9);
        send_item(pett_pkg::OP_EXEC, 23'd200, 23'd3, 16'd0, '1);
        send_item(pett_pkg::OP_EXIT, 23'd200, 23'd0, 16'd0, '0);
        send_item(pett_pkg::OP_EXIT, 23'd300, 23'd0, 16'd0, '0);
        send_item(pett_pkg::OP_FORK, 23'd301, 23'd2, 16'd0, 64'd1);
        send_item(pett_pkg::OP_EXIT, 23'd301, 23'd0, 16'd0, 64'd2);
        send_item(pett_pkg::OP_PTRACE, 23'd55, '1, '1, '1);
        send_item(pett_pkg::OP_OTHER, '1, '1, 16'hffff, '0);
        send_item(pett_pkg::OP_UNKNOWN, 23'd5, 23'd5, 16'd5, 64'd5);
        send_item(3'd7, 23'd5, 23'd5, 16'd5, 64'd5);
        send_item(pett_pkg::OP_EXEC, '0, 23'd1, 16'd1, 64'd1);
        send_item(pett_pkg::OP_EXEC, '1, 23'd4, 16'd0, 64'd3);
        send_item(pett_pkg::OP_EXIT, '1, 23'd0, 16'd0, 64'd3);
        // nine pids on one home with tied stamps force a recycle
        for (int k = 0; k < 9; k++)
            send_item(pett_pkg::OP_FORK, 23'd4095 + 23'(k * TBL_N), 23'(k + 1), 16'd0, 64'd4);
        drain();

        monitor_set = '{23'd0, 23'd8193, 23'd8193, 23'h7fffff, 23'd2};
        report_set = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(pett_pkg::REG_MONITOR_PID, monitor_set[ph % 5]);
            write_reg(pett_pkg::REG_REPORT_MONITOR, pett_pkg::PID_W'(report_set[ph % 5]));
            tx_idle = (ph % 4 == 1) || (ph % 4 == 3);
            rx_idle = (ph % 4 == 2) || (ph % 4 == 3);
            idle_pct = (ph % 4 == 3) ? 10 : 69;
            if (ph == 0)
                hold_go = 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            drain();
        end

        if (sb.pending.size() != 0)
        begin
            $display("%0t: records missing, expected %0d more, actual 0",
                     $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("process_event_tracking_table_top_tb: done, clean");
        else
            $display("process_event_tracking_table_top_tb: done, errors");
        $finish;
    end

endmodule

### files.f
hdl/pett_pkg.sv
hdl/pett_ctrl.sv
hdl/pett_dp.sv
hdl/process_event_tracking_table_top.sv
verif/process_event_tracking_table_top_tb.sv
